/* hdl/dtsp_pkg.sv */
// Shared types and codes for the device tree structure parser.
// No dependencies; the top level and its checker import this package.
package dtsp_pkg;

    // Width of blob positions and emitted offsets
    localparam int OFFSET_WIDTH = 32;
    typedef logic [OFFSET_WIDTH-1:0] t_pos;

    // Header layout: last byte of magic, structure and strings offset words
    localparam int HDR_MAGIC_LAST   = 3;
    localparam int HDR_STRUCT_LAST  = 11;
    localparam int HDR_STRINGS_LAST = 15;
    localparam int HDR_SIZE         = 16;

    localparam logic [31:0] DT_MAGIC = 32'hD00DFEED;

    // Structure block tokens
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    // Parse phases
    typedef logic [2:0] t_phase;
    localparam t_phase PH_HEADER = 3'd0;
    localparam t_phase PH_SKIP   = 3'd1;
    localparam t_phase PH_TOKEN  = 3'd2;
    localparam t_phase PH_NAME   = 3'd3;
    localparam t_phase PH_PLEN   = 3'd4;
    localparam t_phase PH_PNAME  = 3'd5;

    // Event kinds on the result channel
    typedef logic [1:0] t_event;
    localparam t_event EV_PROP      = 2'd0;
    localparam t_event EV_END       = 2'd1;
    localparam t_event EV_BAD_MAGIC = 2'd2;
    localparam t_event EV_BAD_TOKEN = 2'd3;

endpackage

/* hdl/device_tree_structure_parser.sv */
// Device tree structure parser: walks a flattened device tree blob byte by byte
// and reports properties, end of structure and errors. Depends on dtsp_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_ready | i_blob_byte, i_blob_start
//   out     | output    | o_out_valid/ i_out_ready| o_event_kind, o_name_offset,
//           |           |                         | o_value_offset, o_value_length,
//           |           |                         | o_token_word
//
// One byte per cycle sustained while the result is taken; a byte passes the input
// register, then the token state machine, whose output loads the result register.
// The token state machine and its 32-bit adds for the skip count are combinational.
// Synchronous reset clears both stages and leaves the parser stopped until a
// byte marked as blob start arrives. A stalled result holds the byte stage;
// the input side keeps taking a byte while the input register drains.
module device_tree_structure_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_blob_byte,
    input  logic        i_blob_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output dtsp_pkg::t_event o_event_kind,
    output logic [31:0] o_name_offset,
    output logic [31:0] o_value_offset,
    output logic [31:0] o_value_length,
    output logic [31:0] o_token_word
);
    import dtsp_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    // Parser state
    t_pos        r_pos,        n_pos;
    logic [31:0] r_shift,      n_shift;
    logic [1:0]  r_count,      n_count;
    t_phase      r_phase,      n_phase;
    t_pos        r_struct,     n_struct;
    t_pos        r_strings,    n_strings;
    logic [31:0] r_skip,       n_skip;
    logic [31:0] r_held,       n_held;
    logic        r_stopped,    n_stopped;

    // Result register
    logic        r_out_valid,  n_out_valid;
    t_event      r_kind,       n_kind;
    logic [31:0] r_name,       n_name;
    logic [31:0] r_voff,       n_voff;
    logic [31:0] r_vlen,       n_vlen;
    logic [31:0] r_tword,      n_tword;

    // Effective state after a possible restart
    t_pos        e_pos;
    logic [31:0] e_shift;
    logic [1:0]  e_count;
    t_phase      e_phase;
    t_pos        e_struct;
    t_pos        e_strings;
    logic [31:0] e_skip;
    logic [31:0] e_held;
    logic        e_stopped;

    logic        advance;
    t_pos        nxt;
    logic [31:0] shifted;
    logic [1:0]  cnt_inc;
    logic [1:0]  name_pad;
    logic [1:0]  val_pad;
    logic [32:0] val_skip;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign e_pos     = r_in_start ? '0        : r_pos;
    assign e_shift   = r_in_start ? '0        : r_shift;
    assign e_count   = r_in_start ? '0        : r_count;
    assign e_phase   = r_in_start ? PH_HEADER : r_phase;
    assign e_struct  = r_in_start ? '0        : r_struct;
    assign e_strings = r_in_start ? '0        : r_strings;
    assign e_skip    = r_in_start ? '0        : r_skip;
    assign e_held    = r_in_start ? '0        : r_held;
    assign e_stopped = r_in_start ? 1'b0      : r_stopped;

    assign nxt      = e_pos + t_pos'(1);
    assign shifted  = {e_shift[23:0], r_in_byte};
    assign cnt_inc  = e_count + 2'd1;
    // Pad to the next 4-byte boundary after the name terminator
    assign name_pad = 2'd0 - nxt[1:0];
    // Pad after the value: depends only on the low bits of its end
    assign val_pad  = 2'd0 - (nxt[1:0] + e_held[1:0]);
    assign val_skip = {1'b0, e_held} + {31'd0, val_pad};

    // Advance the token state machine by one byte
    always_comb begin
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_count     = r_count;
        n_phase     = r_phase;
        n_struct    = r_struct;
        n_strings   = r_strings;
        n_skip      = r_skip;
        n_held      = r_held;
        n_stopped   = r_stopped;
        n_out_valid = 1'b0;
        n_kind      = EV_PROP;
        n_name      = '0;
        n_voff      = '0;
        n_vlen      = '0;
        n_tword     = '0;

        if (advance) begin
            n_pos     = e_pos;
            n_shift   = e_shift;
            n_count   = e_count;
            n_phase   = e_phase;
            n_struct  = e_struct;
            n_strings = e_strings;
            n_skip    = e_skip;
            n_held    = e_held;
            n_stopped = e_stopped;

            if (!e_stopped) begin
                n_pos = nxt;
                unique case (e_phase)
                    PH_SKIP: begin
                        n_skip = e_skip - 32'd1;
                        if (e_skip == 32'd1) begin
                            n_phase = PH_TOKEN;
                            n_shift = '0;
                            n_count = '0;
                        end
                    end
                    PH_NAME: begin
                        if (r_in_byte == 8'd0) begin
                            n_shift = '0;
                            n_count = '0;
                            if (name_pad == 2'd0) begin
                                n_phase = PH_TOKEN;
                            end else begin
                                n_phase = PH_SKIP;
                                n_skip  = {30'd0, name_pad};
                            end
                        end
                    end
                    PH_HEADER: begin
                        n_shift = shifted;
                        n_count = cnt_inc;
                        if (e_pos == t_pos'(HDR_MAGIC_LAST)) begin
                            if (shifted != DT_MAGIC) begin
                                n_out_valid = 1'b1;
                                n_kind      = EV_BAD_MAGIC;
                                n_tword     = shifted;
                                n_stopped   = 1'b1;
                            end
                        end else if (e_pos == t_pos'(HDR_STRUCT_LAST)) begin
                            n_struct = shifted[OFFSET_WIDTH-1:0];
                        end else if (e_pos == t_pos'(HDR_STRINGS_LAST)) begin
                            n_strings = shifted[OFFSET_WIDTH-1:0];
                            n_shift   = '0;
                            n_count   = '0;
                            if (e_struct > t_pos'(HDR_SIZE)) begin
                                n_phase = PH_SKIP;
                                n_skip  = 32'(e_struct - t_pos'(HDR_SIZE));
                            end else begin
                                n_phase = PH_TOKEN;
                            end
                        end
                    end
                    default: begin
                        // Token phases: collect a big-endian word, act on its last byte
                        n_shift = shifted;
                        n_count = cnt_inc;
                        if (cnt_inc == 2'd0) begin
                            n_shift = '0;
                            if (e_phase == PH_PLEN) begin
                                n_held  = shifted;
                                n_phase = PH_PNAME;
                            end else if (e_phase == PH_PNAME) begin
                                n_out_valid = 1'b1;
                                n_kind      = EV_PROP;
                                n_name      = 32'(e_strings + shifted[OFFSET_WIDTH-1:0]);
                                n_voff      = 32'(nxt);
                                n_vlen      = e_held;
                                if (val_skip == 33'd0) begin
                                    n_phase = PH_TOKEN;
                                end else begin
                                    n_phase = PH_SKIP;
                                    n_skip  = val_skip[32] ? '1 : val_skip[31:0];
                                end
                            end else begin
                                if (shifted == TOK_BEGIN_NODE) begin
                                    n_phase = PH_NAME;
                                end else if (shifted == TOK_PROP) begin
                                    n_phase = PH_PLEN;
                                end else if (shifted == TOK_END) begin
                                    n_out_valid = 1'b1;
                                    n_kind      = EV_END;
                                    n_stopped   = 1'b1;
                                end else if (shifted != TOK_END_NODE &&
                                             shifted != TOK_NOP) begin
                                    n_out_valid = 1'b1;
                                    n_kind      = EV_BAD_TOKEN;
                                    n_tword     = shifted;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Capture an input transaction whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_blob_byte;
            r_in_start <= i_blob_start;
        end
    end

    // Update parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_shift   <= '0;
            r_count   <= '0;
            r_phase   <= PH_HEADER;
            r_struct  <= '0;
            r_strings <= '0;
            r_skip    <= '0;
            r_held    <= '0;
            r_stopped <= 1'b1;
        end else begin
            r_pos     <= n_pos;
            r_shift   <= n_shift;
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_struct  <= n_struct;
            r_strings <= n_strings;
            r_skip    <= n_skip;
            r_held    <= n_held;
            r_stopped <= n_stopped;
        end
    end

    // Load the result register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_out_valid) begin
            r_kind  <= n_kind;
            r_name  <= n_name;
            r_voff  <= n_voff;
            r_vlen  <= n_vlen;
            r_tword <= n_tword;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_name_offset  = r_name;
    assign o_value_offset = r_voff;
    assign o_value_length = r_vlen;
    assign o_token_word   = r_tword;

endmodule

/* hdl/dtsp_checker.sv */
// Port-level checks for the device tree structure parser, bound to the top level.
// Depends on dtsp_pkg and device_tree_structure_parser.
module dtsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input dtsp_pkg::t_event o_event_kind,
    input logic [31:0] o_name_offset,
    input logic [31:0] o_value_offset,
    input logic [31:0] o_value_length,
    input logic [31:0] o_token_word
);
    import dtsp_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_event_kind) &&
            $stable(o_name_offset) && $stable(o_value_offset) &&
            $stable(o_value_length) && $stable(o_token_word))
        else $error("stalled result changed");

    // Only property records carry offsets and length
    a_nonprop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind != EV_PROP |->
            o_name_offset == 32'd0 && o_value_offset == 32'd0 &&
            o_value_length == 32'd0)
        else $error("offsets set on a non-property event");

    // Only error events carry a token word
    a_token_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_PROP || o_event_kind == EV_END) |->
            o_token_word == 32'd0)
        else $error("token word set on a non-error event");

endmodule

bind device_tree_structure_parser dtsp_checker u_dtsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_kind   (o_event_kind),
    .o_name_offset  (o_name_offset),
    .o_value_offset (o_value_offset),
    .o_value_length (o_value_length),
    .o_token_word   (o_token_word)
);
